/* src/mip_pkg.sv */
// ----------------------------------------------------------------------------
// Multiset intersection probe package
// Command codes and the transaction token that travels down the cell chain.
// ----------------------------------------------------------------------------
package mip_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned COMMAND_W = 2;

	typedef enum logic [COMMAND_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_PROBE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic STATUS_MATCH   = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	// One transaction in flight. hit means the load found a free cell or
	// the probe found a matching entry somewhere upstream.
	typedef struct packed {
		logic               vld;
		cmd_t               cmd;
		logic               hit;
		logic [VALUE_W-1:0] val;
	} token_t;

endpackage

/* src/mip_cell.sv */
// ----------------------------------------------------------------------------
// Multiset intersection probe cell
// Holds one store entry and registers the passing transaction for the next
// cell. Clears, loads and probes act on the entry as they pass by.
// ----------------------------------------------------------------------------
module mip_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  mip_pkg::token_t tok_i,
	output mip_pkg::token_t tok_o
);
	import mip_pkg::*;

	logic               used_q;
	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               tok_vld_q;
	token_t             tok_pay_q;

	logic   take_load;
	logic   take_probe;
	logic   do_clear;
	token_t tok_nxt;

	always_comb begin
		do_clear   = tok_i.vld && (tok_i.cmd == CMD_CLEAR);
		take_load  = tok_i.vld && (tok_i.cmd == CMD_LOAD) && !tok_i.hit && !used_q;
		take_probe = tok_i.vld && (tok_i.cmd == CMD_PROBE) && !tok_i.hit
			&& valid_q && (value_q == tok_i.val);
		tok_nxt     = tok_i;
		tok_nxt.hit = tok_i.hit || take_load || take_probe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_i.vld;
			if (do_clear) begin
				used_q  <= 1'b0;
				valid_q <= 1'b0;
			end else if (take_load) begin
				used_q  <= 1'b1;
				valid_q <= 1'b1;
			end else if (take_probe) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_pay_q <= tok_nxt;
		if (take_load) begin
			value_q <= tok_i.val;
		end
	end

	always_comb begin
		tok_o     = tok_pay_q;
		tok_o.vld = tok_vld_q;
	end

	// A live entry is always one that was loaded since the last clear.
	a_valid_used: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> used_q)
		else $error("entry valid without being loaded");

	// A clear leaves this entry empty.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		do_clear |=> (!used_q && !valid_q))
		else $error("entry survived a clear");

	// Once served, a transaction stays served downstream.
	a_hit_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_i.vld && tok_i.hit) |=> (tok_o.vld && tok_o.hit))
		else $error("served transaction lost its hit flag");

	// A load only lands in an entry that was free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		take_load |=> ($rose(used_q) && valid_q))
		else $error("load did not claim a free entry");

endmodule

/* src/multiset_intersection_probe_top.sv */
// ----------------------------------------------------------------------------
// Multiset intersection probe
// Store of loaded elements, probed one element at a time; matched entries are
// consumed so each value is reported as often as the smaller of its counts.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   start, busy, command, value             start & !busy
//  result    result_strobe, status, match_value      result_strobe, one cycle
//
// The store is a chain of STORE_DEPTH cells, one entry per cell. Each
// transaction moves one cell per cycle, so a new command is taken every cycle
// and busy never rises. A result leaves the end of the chain once its command
// has passed every cell; results keep command order.
// Reset empties every entry at once; no clearing pass is needed.
// The receiver cannot stall, so nothing backs up along the chain.
// ----------------------------------------------------------------------------
module multiset_intersection_probe_top #(
	parameter int unsigned STORE_DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [mip_pkg::COMMAND_W-1:0]         command,
	input  logic signed [mip_pkg::VALUE_W-1:0]    value,
	output logic                                  result_strobe,
	output logic                                  status,
	output logic signed [mip_pkg::VALUE_W-1:0]    match_value
);
	import mip_pkg::*;

	token_t head;
	token_t chain [STORE_DEPTH+1];
	token_t tail;

	always_comb begin
		head.vld = start && !busy;
		head.hit = 1'b0;
		head.val = $unsigned(value);
		case (command)
			CMD_CLEAR: head.cmd = CMD_CLEAR;
			CMD_LOAD:  head.cmd = CMD_LOAD;
			CMD_PROBE: head.cmd = CMD_PROBE;
			default:   head.cmd = CMD_NONE;
		endcase
	end

	assign chain[0] = head;

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		mip_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (chain[i]),
			.tok_o  (chain[i+1])
		);
	end

	assign tail = chain[STORE_DEPTH];
	assign busy = 1'b0;

	// A load that found no free entry was dropped; a probe that hit matched.
	always_comb begin
		result_strobe = 1'b0;
		status        = STATUS_MATCH;
		case (tail.cmd)
			CMD_LOAD: begin
				result_strobe = tail.vld && !tail.hit;
				status        = STATUS_DROPPED;
			end
			CMD_PROBE: begin
				result_strobe = tail.vld && tail.hit;
				status        = STATUS_MATCH;
			end
			default: begin
				result_strobe = 1'b0;
				status        = STATUS_MATCH;
			end
		endcase
		match_value = signed'(tail.val);
	end

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.vld && (tail.cmd == CMD_CLEAR || tail.cmd == CMD_NONE)) |-> !result_strobe)
		else $error("clear or unused command produced a result");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && status == STATUS_DROPPED) |-> (tail.cmd == CMD_LOAD))
		else $error("dropped status on a non-load");

endmodule
